/* hdl/slfs_pkg.sv */
// shared types and constants for the sync/length frame splitter
// no dependencies

package slfs_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 7;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h7e;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

  // flags that travel with one buffer read
  typedef struct packed {
    logic last;
    logic err;
  } rd_tag_t;

endpackage

/* hdl/sync_length_frame_splitter.sv */
// once the closing sync byte is taken, bytes go out via the read data and output registers
// throughput: one input byte per cycle while collecting; a frame of n bytes is read out of
//   the single read port at one byte per cycle while out_stall lets it, holding in_stall high
// reset (rst, synchronous): byte count, expected length and handshakes cleared,
//   max_len back to 64; frame buffer contents are left as they were
// top level of the sync/length frame splitter; depends on slfs_pkg, slfs_mem, slfs_ctrl, slfs_out

module sync_length_frame_splitter import slfs_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  // configuration request: largest accepted length field
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  max_frame_len,
  // received bytes
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  // frame bytes
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              frame_end,
  output logic              length_error
);

  // buffer address width and a count that also holds depth + 1 (overflow mark)
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 2);

  logic [LEN_W-1:0]  max_len;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;
  logic              rd_issue;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rdata;
  rd_tag_t           rd_tag;
  logic              rd_room;

  // configuration register; the user writes it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_frame_len;
    end
  end

  // collection writes bytes at the running count; read-out walks the buffer from entry zero
  slfs_ctrl #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .max_len  (max_len),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .rd_room  (rd_room),
    .rd_issue (rd_issue),
    .raddr    (raddr),
    .rd_tag   (rd_tag)
  );

  // frame buffer with registered read data
  slfs_mem #(
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // output register and skid entry; reads are only issued when a slot is free,
  // so a stalled sink never loses a byte and collection can restart meanwhile
  slfs_out u_out (
    .clk          (clk),
    .rst          (rst),
    .rd_issue     (rd_issue),
    .rd_tag       (rd_tag),
    .rdata        (rdata),
    .rd_room      (rd_room),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .frame_end    (frame_end),
    .length_error (length_error)
  );

endmodule

/* hdl/slfs_mem.sv */
// frame buffer: one write port, one read port with registered read data
// depends on slfs_pkg

module slfs_mem import slfs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/slfs_out.sv */
// result stage: output register plus skid entry behind the buffer read port
// depends on slfs_pkg

module slfs_out import slfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_issue,
  input  rd_tag_t           rd_tag,
  input  logic [BYTE_W-1:0] rdata,
  output logic              rd_room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              frame_end,
  output logic              length_error
);

  logic              inflight;
  rd_tag_t           inflight_tag;
  logic              skid_valid;
  logic [BYTE_W-1:0] skid_byte;
  rd_tag_t           skid_tag;
  logic              pop;
  logic [1:0]        occ;

  assign pop = out_valid && !out_stall;
  assign occ = 2'(out_valid) + 2'(skid_valid) + 2'(inflight) - 2'(pop);
  assign rd_room = (occ < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight   <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      inflight <= rd_issue;
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= inflight;
        end else begin
          out_valid <= inflight;
        end
      end else if (inflight) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inflight_tag <= rd_tag;
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_byte     <= skid_byte;
        frame_end    <= skid_tag.last;
        length_error <= skid_tag.err;
        skid_byte    <= rdata;
        skid_tag     <= inflight_tag;
      end else begin
        out_byte     <= rdata;
        frame_end    <= inflight_tag.last;
        length_error <= inflight_tag.err;
      end
    end else if (inflight) begin
      skid_byte <= rdata;
      skid_tag  <= inflight_tag;
    end
  end

endmodule

/* hdl/slfs_ctrl.sv */
// byte collection and frame read-out sequencer
// depends on slfs_pkg; drives the slfs_mem ports

module slfs_ctrl import slfs_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LEN_W-1:0]  max_len,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              we,
  output logic [AW-1:0]     waddr,
  output logic [BYTE_W-1:0] wdata,
  input  logic              rd_room,
  output logic              rd_issue,
  output logic [AW-1:0]     raddr,
  output rd_tag_t           rd_tag
);

  localparam int CMPW = (CW > 9) ? CW : 9;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [LEN_W-1:0]  expected;
  logic [BYTE_W-1:0] first_byte;
  logic [AW-1:0]     last_addr;
  logic              frame_err;

  logic              accept;
  logic              full;
  logic [CMPW-1:0]   cnt_w;
  logic [CMPW-1:0]   cnt_new;
  logic [8:0]        len9;
  logic [LEN_W-1:0]  exp_new;
  logic [CMPW-1:0]   exp_w;
  logic              emit;
  logic              err_new;
  logic [CMPW-1:0]   n_w;
  logic              rd_last;

  assign accept = in_valid && !in_stall;
  assign cnt_w  = CMPW'(count);
  assign full   = (cnt_w >= CMPW'(DEPTH));
  assign cnt_new = full ? CMPW'(DEPTH + 1) : cnt_w + CMPW'(1);

  always_comb begin
    if (cnt_new == CMPW'(2)) begin
      if (first_byte != SYNC_BYTE) begin
        len9 = 9'(first_byte);
      end else begin
        len9 = 9'(in_byte) + 9'd1;
      end
      exp_new = (len9 > 9'(max_len)) ? '0 : len9[LEN_W-1:0];
    end else begin
      len9    = '0;
      exp_new = expected;
    end
  end

  assign exp_w   = CMPW'(exp_new);
  assign emit    = (in_byte == SYNC_BYTE) && (cnt_new >= CMPW'(2)) && (exp_w <= cnt_new);
  assign err_new = (cnt_new > CMPW'(max_len)) || (cnt_new > exp_w) ||
                   (cnt_new > CMPW'(DEPTH));
  assign n_w     = full ? CMPW'(DEPTH) : cnt_new;

  assign we    = accept && !full;
  assign waddr = count[AW-1:0];
  assign wdata = in_byte;

  assign rd_issue   = (state == ST_EMIT) && rd_room;
  assign rd_last    = (raddr == last_addr);
  assign rd_tag.last = rd_last;
  assign rd_tag.err  = rd_last && frame_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      in_stall <= 1'b0;
      count    <= '0;
      expected <= '0;
      raddr    <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (accept) begin
            expected <= exp_new;
            if (count == '0) begin
              first_byte <= in_byte;
            end
            if (emit) begin
              count     <= '0;
              last_addr <= AW'(n_w - CMPW'(1));
              frame_err <= err_new;
              raddr     <= '0;
              in_stall  <= 1'b1;
              state     <= ST_EMIT;
            end else begin
              count <= CW'(cnt_new);
            end
          end
        end
        ST_EMIT: begin
          if (rd_issue) begin
            if (rd_last) begin
              in_stall <= 1'b0;
              state    <= ST_COLLECT;
            end else begin
              raddr <= raddr + AW'(1);
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule
